/* src/ggs_pkg.sv */
`default_nettype none

package ggs_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int IR_W      = 10;
    localparam int PULSE_W   = 12;
    localparam int TIMEOUT_W = 16;
    localparam int STATE_W   = 3;
    localparam int EVENT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // countdown width
    localparam int TIMER_BITS = 16;

    // operations
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_MANUAL  = 2'd1;
    localparam logic [OP_W-1:0] OP_AUTO    = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    // sequencer states
    localparam logic [STATE_W-1:0] ST_OPEN    = 3'd0;
    localparam logic [STATE_W-1:0] ST_SEARCH  = 3'd1;
    localparam logic [STATE_W-1:0] ST_CLOSING = 3'd2;
    localparam logic [STATE_W-1:0] ST_CHECK   = 3'd3;
    localparam logic [STATE_W-1:0] ST_STOCKED = 3'd4;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_GAVEUP   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STOCKED  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FAIL     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IR_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PULSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_PULSE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSING_TO   = 3'd4;

    // register reset values
    localparam logic [IR_W-1:0]      RST_IR_THRESHOLD = 10'd300;
    localparam logic [PULSE_W-1:0]   RST_OPEN_PULSE   = 12'd1000;
    localparam logic [PULSE_W-1:0]   RST_LOCK_PULSE   = 12'd2000;
    localparam logic [TIMEOUT_W-1:0] RST_SEARCH_TO    = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] RST_CLOSING_TO   = 16'd50;

    typedef struct packed {
        logic [IR_W-1:0]      ir_threshold;
        logic [PULSE_W-1:0]   open_pulse_us;
        logic [PULSE_W-1:0]   lock_pulse_us;
        logic [TIMEOUT_W-1:0] search_timeout;
        logic [TIMEOUT_W-1:0] closing_timeout;
    } t_cfg;

    typedef struct packed {
        logic [STATE_W-1:0]    fsm_state;
        logic                  timer_armed;
        logic [TIMER_BITS-1:0] timer_remaining;
    } t_seq_state;

    typedef struct packed {
        logic [STATE_W-1:0] fsm_now;
        logic [PULSE_W-1:0] servo_pulse_us;
        logic               part_present;
        logic [EVENT_W-1:0] event_code;
    } t_result;

endpackage

`default_nettype wire

/* src/ir_gated_gripper_sequencer.sv */
`default_nettype none

// IR-gated gripper sequencer: open, search, closing, check, stocked.
// Input channel (i_valid/o_ready) carries an operation (tick with IR sample,
// manual stock, auto stock, release); output channel (o_valid/i_ready)
// returns exactly one result per input transaction: state, servo pulse
// width, part-present flag and event code.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_index,
// i_cfg_data); writes take effect at the clock edge and go unanswered.
// Path: a transaction accepted at one edge is latched in the input
// register, then settled through the state logic into the result register
// once that register is free or being taken, and its result is offered there.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the combinational state update between the input and result registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, after which o_ready drops until the
// result is taken.
// Reset (synchronous, active low) returns the sequencer to open with the
// countdown disarmed, empties both registers and restores register defaults.

module ir_gated_gripper_sequencer
    import ggs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [IR_W-1:0]      i_ir_sample,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [STATE_W-1:0]        o_fsm_now,
    output logic [PULSE_W-1:0]        o_servo_pulse_us,
    output logic                      o_part_present,
    output logic [EVENT_W-1:0]        o_event_code
);

    t_cfg       cfg;
    t_seq_state r_seq;
    t_seq_state n_seq;
    t_result    n_result;
    t_result    r_result;

    logic            r_in_valid;
    logic [OP_W-1:0] r_operation;
    logic [IR_W-1:0] r_ir_sample;
    logic            r_out_valid;
    logic            advance;

    ggs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ggs_step u_step (
        .i_cfg       (cfg),
        .i_cur       (r_seq),
        .i_operation (r_operation),
        .i_ir_sample (r_ir_sample),
        .o_next      (n_seq),
        .o_result    (n_result)
    );

    // move the held transaction into the result register
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_operation <= i_operation;
            r_ir_sample <= i_ir_sample;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq.fsm_state       <= ST_OPEN;
            r_seq.timer_armed     <= 1'b0;
            r_seq.timer_remaining <= '0;
        end else if (advance) begin
            r_seq <= n_seq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fsm_now        = r_result.fsm_now;
    assign o_servo_pulse_us = r_result.servo_pulse_us;
    assign o_part_present   = r_result.part_present;
    assign o_event_code     = r_result.event_code;

endmodule

`default_nettype wire

/* src/ggs_cfg_regs.sv */
`default_nettype none

module ggs_cfg_regs
    import ggs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ir_threshold    <= RST_IR_THRESHOLD;
            r_cfg.open_pulse_us   <= RST_OPEN_PULSE;
            r_cfg.lock_pulse_us   <= RST_LOCK_PULSE;
            r_cfg.search_timeout  <= RST_SEARCH_TO;
            r_cfg.closing_timeout <= RST_CLOSING_TO;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IR_THRESHOLD: r_cfg.ir_threshold    <= i_cfg_data[IR_W-1:0];
                CFG_OPEN_PULSE:   r_cfg.open_pulse_us   <= i_cfg_data[PULSE_W-1:0];
                CFG_LOCK_PULSE:   r_cfg.lock_pulse_us   <= i_cfg_data[PULSE_W-1:0];
                CFG_SEARCH_TO:    r_cfg.search_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_CLOSING_TO:   r_cfg.closing_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/ggs_step.sv */
`default_nettype none

module ggs_step
    import ggs_pkg::*;
(
    input  wire t_cfg             i_cfg,
    input  wire t_seq_state       i_cur,
    input  wire logic [OP_W-1:0]  i_operation,
    input  wire logic [IR_W-1:0]  i_ir_sample,
    output t_seq_state            o_next,
    output t_result               o_result
);

    logic                  seen;
    logic [STATE_W-1:0]    st;
    logic                  armed;
    logic [TIMER_BITS-1:0] rem;
    logic [EVENT_W-1:0]    ev;

    assign seen = i_ir_sample > i_cfg.ir_threshold;

    // one transaction worth of sequencer moves, applied in order
    always_comb begin
        st    = i_cur.fsm_state;
        armed = i_cur.timer_armed;
        rem   = i_cur.timer_remaining;
        ev    = EV_NONE;
        case (i_operation)
            OP_TICK: begin
                // countdown first
                if (armed) begin
                    if (rem == '0) begin
                        armed = 1'b0;
                        if (st == ST_SEARCH) begin
                            st = ST_OPEN;
                            ev = EV_GAVEUP;
                        end else if (st == ST_CLOSING) begin
                            st = ST_CHECK;
                        end
                    end else begin
                        rem = rem - 1'b1;
                    end
                end
                // detection while searching
                if (st == ST_SEARCH && seen) begin
                    st    = ST_CLOSING;
                    armed = 1'b1;
                    rem   = TIMER_BITS'(i_cfg.closing_timeout);
                end
                // presence check settles in the same transaction
                if (st == ST_CHECK) begin
                    armed = 1'b0;
                    if (seen) begin
                        st = ST_STOCKED;
                        ev = EV_STOCKED;
                    end else begin
                        st = ST_OPEN;
                        ev = EV_FAIL;
                    end
                end
            end
            OP_MANUAL: begin
                if (st == ST_OPEN) begin
                    st    = ST_CLOSING;
                    armed = 1'b1;
                    rem   = TIMER_BITS'(i_cfg.closing_timeout);
                end
            end
            OP_AUTO: begin
                if (st == ST_OPEN) begin
                    st    = ST_SEARCH;
                    armed = 1'b1;
                    rem   = TIMER_BITS'(i_cfg.search_timeout);
                end
            end
            OP_RELEASE: begin
                if (st == ST_STOCKED) begin
                    st    = ST_OPEN;
                    armed = 1'b0;
                    ev    = EV_RELEASED;
                end
            end
            default: ;
        endcase
    end

    assign o_next.fsm_state       = st;
    assign o_next.timer_armed     = armed;
    assign o_next.timer_remaining = rem;

    // result fields from the new state
    assign o_result.fsm_now        = st;
    assign o_result.servo_pulse_us = (st == ST_OPEN || st == ST_SEARCH) ?
                                     i_cfg.open_pulse_us : i_cfg.lock_pulse_us;
    assign o_result.part_present   = (st == ST_STOCKED);
    assign o_result.event_code     = ev;

endmodule

`default_nettype wire
